// ===== hw/rtl/free_running_timer_compare_core_defines.svh =====
// Assertion macros for the free-running timer core.
// Included by RTL files that check their own logic; no other dependencies.
`ifndef FREE_RUNNING_TIMER_COMPARE_CORE_DEFINES_SVH
`define FREE_RUNNING_TIMER_COMPARE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define FRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FRTC_ASSERT_NOW(label, ante, cons, msg)
`define FRTC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/frtc_pkg.sv =====
// Shared types, register offsets and helper functions of the timer core.
// No dependencies; used by the command channel interface and the core.
`timescale 1ns / 1ps
`default_nettype none

package frtc_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef logic [3:0] offset_t;

    localparam offset_t OFF_ENABLE  = 4'd0;
    localparam offset_t OFF_STATUS  = 4'd1;
    localparam offset_t OFF_CNT_HI  = 4'd2;
    localparam offset_t OFF_CNT_LO  = 4'd3;
    localparam offset_t OFF_CMP_HI  = 4'd4;
    localparam offset_t OFF_CMP_LO  = 4'd5;
    localparam offset_t OFF_CLK_SEL = 4'd6;
    localparam offset_t OFF_OUT_CTL = 4'd7;

    // status bits
    localparam int BIT_OCFA = 3;
    localparam int BIT_OCFB = 2;
    localparam int BIT_OVF  = 1;
    localparam int BIT_CCLR = 0;
    // output control bit choosing compare B
    localparam int BIT_CMP_SEL = 4;

    localparam logic [7:0]  ENABLE_RESET  = 8'h01;
    localparam logic [7:0]  OUT_CTL_FIXED = 8'hE0;
    localparam logic [7:0]  IRQ_MASK      = 8'hFE;
    localparam logic [15:0] COUNT_TOP     = 16'hFFFF;

    // prescaler divider for clock select bits 1..0
    function automatic logic [5:0] prescale_limit(input logic [1:0] sel);
        logic [5:0] lim;
        case (sel)
            2'd0:    lim = 6'd2;
            2'd1:    lim = 6'd8;
            2'd2:    lim = 6'd32;
            default: lim = 6'd2;
        endcase
        return lim;
    endfunction

    // {pending, source}: source = 7 - bit of the highest set flag in 7..1
    function automatic logic [3:0] irq_select(input logic [7:0] flags);
        logic       pend;
        logic [2:0] src;
        pend = 1'b0;
        src  = 3'd0;
        for (int b = 1; b < 8; b++) begin
            if (flags[b]) begin
                pend = 1'b1;
                src  = 3'(7 - b);
            end
        end
        return {pend, src};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frtc_cmd_if.sv =====
// Command channel: tick, byte register write, byte register read or no operation.
// Depends on frtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface frtc_cmd_if;
    logic                valid;
    logic                ready;
    frtc_pkg::func_t     func;
    frtc_pkg::offset_t   reg_offset;
    logic [7:0]          write_data;

    modport source (output valid, output func, output reg_offset, output write_data,
                    input ready);
    modport sink   (input valid, input func, input reg_offset, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frtc_rsp_if.sv =====
// Response channel: read data and interrupt status, one per command.
// No dependencies; plain logic payload.
`timescale 1ns / 1ps
`default_nettype none

interface frtc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_pending;
    logic [2:0] irq_source;

    modport source (output valid, output read_data, output irq_pending, output irq_source,
                    input ready);
    modport sink   (input valid, input read_data, input irq_pending, input irq_source,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/free_running_timer_compare_core.sv =====
// 16-bit free-running timer with two output compares and byte register access.
// Depends on frtc_pkg, frtc_cmd_if, frtc_rsp_if and the assertion macro header.
//
// Usage:
//   cmd carries one transaction per system tick (func = tick) or per bus access
//   (func = write / read, reg_offset, write_data). Every accepted command
//   produces exactly one transaction on rsp: read_data (zero unless a read)
//   and the highest-priority enabled pending interrupt after the command.
//   Latency: the response is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while rsp is not stalled; all state is updated by one pass of
//   logic (16-bit compares, increment, priority encoder) into the registers.
//   Stall: the response register holds until rsp.ready; cmd.ready stays high
//   while the response register is empty or being drained in the same cycle,
//   so a stalled receiver stops commands only after one response waits.
//   Reset (rst_n low, async): counter 0, compares 0xFFFF, enable 0x01,
//   output control 0xE0, other state 0, no response pending; the response payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "free_running_timer_compare_core_defines.svh"

module free_running_timer_compare_core (
    input  wire logic clk,
    input  wire logic rst_n,
    frtc_cmd_if.sink  cmd,
    frtc_rsp_if.source rsp
);

    logic [15:0] free_count_reg, free_count_next;
    logic [15:0] compare_a_reg, compare_a_next;
    logic [15:0] compare_b_reg, compare_b_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  irq_enable_reg, irq_enable_next;
    logic [7:0]  clock_select_reg, clock_select_next;
    logic [7:0]  output_control_reg, output_control_next;
    logic [7:0]  byte_latch_reg, byte_latch_next;
    logic [4:0]  prescale_reg, prescale_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [2:0]  irq_source_reg, irq_source_next;

    logic        cmd_fire;
    logic [5:0]  prescale_inc;
    logic [15:0] cmp_sel;
    logic [3:0]  irq_info;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign prescale_inc = {1'b0, prescale_reg} + 6'd1;
    assign cmp_sel = output_control_reg[frtc_pkg::BIT_CMP_SEL] ? compare_b_reg : compare_a_reg;

    always_comb
    begin
        free_count_next     = free_count_reg;
        compare_a_next      = compare_a_reg;
        compare_b_next      = compare_b_reg;
        status_next         = status_reg;
        irq_enable_next     = irq_enable_reg;
        clock_select_next   = clock_select_reg;
        output_control_next = output_control_reg;
        byte_latch_next     = byte_latch_reg;
        prescale_next       = prescale_reg;
        read_data_next      = 8'd0;

        if (cmd_fire)
        begin
            case (cmd.func)
                frtc_pkg::FUNC_TICK:
                begin
                    if (prescale_inc >= frtc_pkg::prescale_limit(clock_select_reg[1:0]))
                    begin
                        prescale_next = 5'd0;
                        if (free_count_reg == compare_a_reg && status_reg[frtc_pkg::BIT_CCLR])
                        begin
                            // clear on match A; B flag only if B coincides with A
                            status_next[frtc_pkg::BIT_OCFA] = 1'b1;
                            if (compare_b_reg == compare_a_reg)
                                status_next[frtc_pkg::BIT_OCFB] = 1'b1;
                            free_count_next = 16'd0;
                        end
                        else
                        begin
                            if (free_count_reg == compare_a_reg)
                                status_next[frtc_pkg::BIT_OCFA] = 1'b1;
                            if (free_count_reg == compare_b_reg)
                                status_next[frtc_pkg::BIT_OCFB] = 1'b1;
                            if (free_count_reg == frtc_pkg::COUNT_TOP)
                                status_next[frtc_pkg::BIT_OVF] = 1'b1;
                            free_count_next = free_count_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_inc[4:0];
                    end
                end
                frtc_pkg::FUNC_WRITE:
                begin
                    case (cmd.reg_offset)
                        frtc_pkg::OFF_ENABLE:  irq_enable_next = cmd.write_data | 8'h01;
                        frtc_pkg::OFF_STATUS:
                            status_next = (status_reg & cmd.write_data)
                                        | {7'd0, cmd.write_data[frtc_pkg::BIT_CCLR]};
                        frtc_pkg::OFF_CNT_HI:  byte_latch_next = cmd.write_data;
                        frtc_pkg::OFF_CNT_LO:  free_count_next = {byte_latch_reg, cmd.write_data};
                        frtc_pkg::OFF_CMP_HI:  byte_latch_next = cmd.write_data;
                        frtc_pkg::OFF_CMP_LO:
                        begin
                            if (output_control_reg[frtc_pkg::BIT_CMP_SEL])
                                compare_b_next = {byte_latch_reg, cmd.write_data};
                            else
                                compare_a_next = {byte_latch_reg, cmd.write_data};
                        end
                        frtc_pkg::OFF_CLK_SEL: clock_select_next = cmd.write_data;
                        frtc_pkg::OFF_OUT_CTL:
                            output_control_next = cmd.write_data | frtc_pkg::OUT_CTL_FIXED;
                        default: ;
                    endcase
                end
                frtc_pkg::FUNC_READ:
                begin
                    case (cmd.reg_offset)
                        frtc_pkg::OFF_ENABLE:  read_data_next = irq_enable_reg;
                        frtc_pkg::OFF_STATUS:  read_data_next = status_reg;
                        frtc_pkg::OFF_CNT_HI:
                        begin
                            read_data_next  = free_count_reg[15:8];
                            byte_latch_next = free_count_reg[7:0];
                        end
                        frtc_pkg::OFF_CNT_LO:  read_data_next = byte_latch_reg;
                        frtc_pkg::OFF_CMP_HI:  read_data_next = cmp_sel[15:8];
                        frtc_pkg::OFF_CMP_LO:  read_data_next = cmp_sel[7:0];
                        frtc_pkg::OFF_CLK_SEL: read_data_next = clock_select_reg;
                        frtc_pkg::OFF_OUT_CTL: read_data_next = output_control_reg;
                        default:               read_data_next = 8'd0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign irq_info = frtc_pkg::irq_select(irq_enable_next & status_next & frtc_pkg::IRQ_MASK);
    assign irq_pending_next = irq_info[3];
    assign irq_source_next  = irq_info[2:0];

    always_comb
    begin
        if (cmd_fire)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg     <= 16'd0;
            compare_a_reg      <= frtc_pkg::COUNT_TOP;
            compare_b_reg      <= frtc_pkg::COUNT_TOP;
            status_reg         <= 8'd0;
            irq_enable_reg     <= frtc_pkg::ENABLE_RESET;
            clock_select_reg   <= 8'd0;
            output_control_reg <= frtc_pkg::OUT_CTL_FIXED;
            byte_latch_reg     <= 8'd0;
            prescale_reg       <= 5'd0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            free_count_reg     <= free_count_next;
            compare_a_reg      <= compare_a_next;
            compare_b_reg      <= compare_b_next;
            status_reg         <= status_next;
            irq_enable_reg     <= irq_enable_next;
            clock_select_reg   <= clock_select_next;
            output_control_reg <= output_control_next;
            byte_latch_reg     <= byte_latch_next;
            prescale_reg       <= prescale_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    // response payload, loaded only with a new transaction
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            read_data_reg   <= read_data_next;
            irq_pending_reg <= irq_pending_next;
            irq_source_reg  <= irq_source_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.irq_pending = irq_pending_reg;
    assign rsp.irq_source  = irq_source_reg;

    `FRTC_ASSERT_NOW(a_no_overwrite, cmd_fire && rsp_valid_reg, rsp.ready, "response overwritten while stalled")
    `FRTC_ASSERT_NOW(a_src_idle, rsp_valid_reg && !irq_pending_reg, irq_source_reg == 3'd0, "irq source set with no pending irq")
    `FRTC_ASSERT_NOW(a_fixed_bits, 1'b1, irq_enable_reg[0] && output_control_reg[7:5] == 3'b111, "fixed register bits lost")
    `FRTC_ASSERT_NEXT(a_cnt_load, cmd_fire && cmd.func == frtc_pkg::FUNC_WRITE && cmd.reg_offset == frtc_pkg::OFF_CNT_LO, free_count_reg == {$past(byte_latch_reg), $past(cmd.write_data)}, "counter load through byte latch failed")

endmodule

`default_nettype wire
